[sv/gcgu_pkg.sv]
// Shared types and constants for the grid cell growth update unit.
`default_nettype none

package gcgu_pkg;

  localparam int VAL_W   = 32;   // Q16.16 cell value
  localparam int WGT_W   = 16;   // Q8.8 weight
  localparam int COORD_W = 8;    // signed working width of cell coordinates
  localparam int LBL_W   = 3;    // reported column/row bits
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int FAC_W   = 40;   // Q24.16 growth factor

  localparam logic [VAL_W-1:0] CELL_ONE     = 32'h0001_0000;
  localparam logic [VAL_W-1:0] CELL_MAX_RST = 32'h000A_0000;

  typedef enum logic [1:0] {
    FACE_0   = 2'd0,
    FACE_90  = 2'd1,
    FACE_180 = 2'd2,
    FACE_270 = 2'd3
  } face_t;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_CB   = 3'd1,   // common * base
    MUL_RW   = 3'd2,   // (common * base) * road, gives factor
    MUL_LO   = 3'd3,   // cell * factor low half
    MUL_HI   = 3'd4    // cell * factor high part
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    logic    rd;
    logic    commit;
    logic    last;
    logic    clr;
    logic    cand_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cand_ok;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[sv/gcgu_in_if.sv]
// Detection input channel.
`default_nettype none

interface gcgu_in_if;
  logic              valid;
  logic              ready;
  logic signed [3:0] node_x;
  logic signed [3:0] node_y;
  logic [1:0]        facing;
  logic [15:0]       common_weight;
  logic [15:0]       base_weight;
  logic [15:0]       road_weight;

  modport source (
    output valid, node_x, node_y, facing, common_weight, base_weight, road_weight,
    input  ready
  );
  modport sink (
    input  valid, node_x, node_y, facing, common_weight, base_weight, road_weight,
    output ready
  );
endinterface

`default_nettype wire

[sv/gcgu_out_if.sv]
// Updated cell result channel.
`default_nettype none

interface gcgu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cell_col;
  logic [2:0]  cell_row;
  logic [31:0] cell_value;
  logic        was_clamped;
  logic        last_of_run;

  modport source (
    output valid, cell_col, cell_row, cell_value, was_clamped, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, cell_col, cell_row, cell_value, was_clamped, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

[sv/gcgu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gcgu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/gcgu_ctrl.sv]
// Sequencer: clearing pass, factor build, then read-multiply-write per cell.
`default_nettype none

module gcgu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gcgu_pkg::dp_stat_t  stat,
  output gcgu_pkg::ctrl_cmd_t      cmd
);
  import gcgu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FAC1,
    S_FAC2,
    S_SEL,
    S_LO,
    S_HI,
    S_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;
  logic   last;

  // current candidate is the final one if it is the second or the second is off-grid
  assign last     = sel_r || !stat.cand_ok[1];
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    cmd          = '0;
    cmd.mul_op   = MUL_NONE;
    cmd.cand_sel = sel_r;
    cmd.last     = last;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FAC1;
        end
      end
      S_FAC1: begin
        cmd.mul_op = MUL_CB;
        state_nxt  = S_FAC2;
      end
      S_FAC2: begin
        cmd.mul_op = MUL_RW;
        sel_nxt    = 1'b0;
        state_nxt  = S_SEL;
      end
      S_SEL: begin
        priority if (stat.cand_ok[sel_r]) begin
          cmd.rd    = 1'b1;
          state_nxt = S_LO;
        end else if (sel_r) begin
          state_nxt = S_IDLE;
        end else begin
          sel_nxt = 1'b1;
        end
      end
      S_LO: begin
        cmd.mul_op = MUL_LO;
        state_nxt  = S_HI;
      end
      S_HI: begin
        cmd.mul_op = MUL_HI;
        state_nxt  = S_WR;
      end
      S_WR: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            sel_nxt   = 1'b1;
            state_nxt = S_SEL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/gcgu_dpath.sv]
// Datapath: coordinate mapping, shared multiplier, saturation, grid RAM, result register.
`default_nettype none

module gcgu_dpath #(
  parameter int CELL_COLS = 8,
  parameter int CELL_ROWS = 8,
  parameter int NODE_ROWS = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gcgu_pkg::ctrl_cmd_t cmd,
  output gcgu_pkg::dp_stat_t       stat,
  input  wire logic signed [3:0]   in_node_x,
  input  wire logic signed [3:0]   in_node_y,
  input  wire logic [1:0]          in_facing,
  input  wire logic [15:0]         in_common_weight,
  input  wire logic [15:0]         in_base_weight,
  input  wire logic [15:0]         in_road_weight,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_cell_col,
  output logic [2:0]               out_cell_row,
  output logic [31:0]              out_cell_value,
  output logic                     out_was_clamped,
  output logic                     out_last_of_run
);
  import gcgu_pkg::*;

  localparam int DEPTH  = CELL_COLS * CELL_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic signed [COORD_W-1:0] COLS_S  = COORD_W'(CELL_COLS);
  localparam logic signed [COORD_W-1:0] ROWS_S  = COORD_W'(CELL_ROWS);
  localparam logic signed [COORD_W-1:0] NROWS_S = COORD_W'(NODE_ROWS);
  localparam logic signed [COORD_W-1:0] ONE_S   = COORD_W'(1);
  localparam logic signed [COORD_W-1:0] TWO_S   = COORD_W'(2);

  // latched detection
  logic signed [3:0]  nx_r, ny_r;
  face_t              face_r;
  logic [WGT_W-1:0]   cw_r, bw_r, rw_r;

  logic [PROD_W-1:0]  prod_r;
  logic [FAC_W-1:0]   factor_r;
  logic [VAL_W-1:0]   cell_r;
  logic [VAL_W-1:0]   lo_r;
  logic [VAL_W-1:0]   cell_max_r;
  logic [ADDR_W-1:0]  clr_cnt_r;

  logic               out_valid_r, out_valid_nxt;
  logic [LBL_W-1:0]   out_col_r, out_row_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_clamp_r, out_last_r;

  // candidate cells
  logic signed [COORD_W-1:0] cx, cy, cxm, cym;
  logic signed [COORD_W-1:0] col_c [2];
  logic signed [COORD_W-1:0] row_c [2];
  logic [ADDR_W-1:0]         addr_c [2];
  logic [1:0]                ok_c;
  logic signed [COORD_W-1:0] col_s, row_s;
  logic [ADDR_W-1:0]         addr_s;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  product;

  logic [VAL_W-1:0]   rd_data;
  logic [PROD_W:0]    sum;
  logic               clamp;
  logic [VAL_W-1:0]   new_val;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]   ram_wdata;

  assign cx  = {{(COORD_W-4){nx_r[3]}}, nx_r} + ONE_S;
  assign cy  = NROWS_S - {{(COORD_W-4){ny_r[3]}}, ny_r} - TWO_S;
  assign cxm = cx - ONE_S;
  assign cym = cy - ONE_S;

  always_comb begin
    unique case (face_r)
      FACE_0: begin
        col_c[0] = cx;  row_c[0] = cym;
        col_c[1] = cxm; row_c[1] = cym;
      end
      FACE_90: begin
        col_c[0] = cx;  row_c[0] = cy;
        col_c[1] = cx;  row_c[1] = cym;
      end
      FACE_180: begin
        col_c[0] = cx;  row_c[0] = cy;
        col_c[1] = cxm; row_c[1] = cy;
      end
      FACE_270: begin
        col_c[0] = cxm; row_c[0] = cy;
        col_c[1] = cxm; row_c[1] = cym;
      end
    endcase
  end

  for (genvar k = 0; k < 2; k++) begin : g_cand
    assign ok_c[k] = !col_c[k][COORD_W-1] && (col_c[k] < COLS_S) &&
                     !row_c[k][COORD_W-1] && (row_c[k] < ROWS_S);
    assign addr_c[k] = ADDR_W'(32'($unsigned(row_c[k])) * 32'(CELL_COLS) +
                               32'($unsigned(col_c[k])));
  end

  assign col_s  = cmd.cand_sel ? col_c[1]  : col_c[0];
  assign row_s  = cmd.cand_sel ? row_c[1]  : row_c[0];
  assign addr_s = cmd.cand_sel ? addr_c[1] : addr_c[0];

  // one shared 32x24 multiplier
  always_comb begin
    unique case (cmd.mul_op)
      MUL_CB: begin
        mul_a = MUL_A_W'(cw_r);
        mul_b = MUL_B_W'(bw_r);
      end
      MUL_RW: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(rw_r);
      end
      MUL_LO: begin
        mul_a = rd_data;
        mul_b = MUL_B_W'(factor_r[15:0]);
      end
      MUL_HI: begin
        mul_a = cell_r;
        mul_b = factor_r[FAC_W-1:16];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign sum     = {1'b0, prod_r} + (PROD_W+1)'(lo_r);
  assign clamp   = sum > (PROD_W+1)'(cell_max_r);
  assign new_val = clamp ? cell_max_r : sum[VAL_W-1:0];

  assign ram_we    = cmd.clr || cmd.commit;
  assign ram_waddr = cmd.clr ? clr_cnt_r : addr_s;
  assign ram_wdata = cmd.clr ? CELL_ONE  : new_val;

  gcgu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (addr_s),
    .rdata (rd_data)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nx_r   <= in_node_x;
      ny_r   <= in_node_y;
      face_r <= face_t'(in_facing);
      cw_r   <= in_common_weight;
      bw_r   <= in_base_weight;
      rw_r   <= in_road_weight;
    end
    unique case (cmd.mul_op)
      MUL_CB: prod_r <= product;
      MUL_RW: factor_r <= product[FAC_W+7:8];
      MUL_LO: begin
        cell_r <= rd_data;
        prod_r <= product;
      end
      MUL_HI: begin
        lo_r   <= prod_r[VAL_W+15:16];
        prod_r <= product;
      end
      default: ;
    endcase
    if (cmd.commit) begin
      out_col_r   <= col_s[LBL_W-1:0];
      out_row_r   <= row_s[LBL_W-1:0];
      out_val_r   <= new_val;
      out_clamp_r <= clamp;
      out_last_r  <= cmd.last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      cell_max_r  <= CELL_MAX_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (cfg_we) begin
        cell_max_r <= cfg_wdata;
      end
    end
  end

  assign stat.cand_ok  = ok_c;
  assign stat.clr_last = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_cell_col    = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_cell_value  = out_val_r;
  assign out_was_clamped = out_clamp_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

[sv/grid_cell_growth_update_unit.sv]
// Top level of the grid cell growth update unit.
//
//  channel | dir | carries                                      | transfer
//  --------+-----+----------------------------------------------+---------------------
//  in_ch   | in  | node_x, node_y, facing, three Q8.8 weights   | valid & ready
//  out_ch  | out | cell_col, cell_row, cell_value, was_clamped, | valid & ready
//          |     | last_of_run                                  |
//  cfg_    | in  | cell_max (Q16.16 ceiling)                    | cfg_we high
//
// Flow: transfer, then the factor build (common*base, then times road) through
// the shared 32x24 multiplier, then per on-grid cell select/read, low product,
// high product, saturate/write; off-grid candidates are skipped. Detections
// are taken one at a time.
// Reset: a clearing pass writes 1.0 to every cell; no detection is taken
// meanwhile, cfg writes still are.
// Stalls: a full output register holds any cell write until it drains; the
// next detection is still taken while a result waits.
`default_nettype none

module grid_cell_growth_update_unit #(
  parameter int CELL_COLS = 8,
  parameter int CELL_ROWS = 8,
  parameter int NODE_ROWS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gcgu_in_if.sink          in_ch,
  gcgu_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import gcgu_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  gcgu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcgu_dpath #(
    .CELL_COLS (CELL_COLS),
    .CELL_ROWS (CELL_ROWS),
    .NODE_ROWS (NODE_ROWS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_node_x        (in_ch.node_x),
    .in_node_y        (in_ch.node_y),
    .in_facing        (in_ch.facing),
    .in_common_weight (in_ch.common_weight),
    .in_base_weight   (in_ch.base_weight),
    .in_road_weight   (in_ch.road_weight),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_cell_col     (out_ch.cell_col),
    .out_cell_row     (out_ch.cell_row),
    .out_cell_value   (out_ch.cell_value),
    .out_was_clamped  (out_ch.was_clamped),
    .out_last_of_run  (out_ch.last_of_run)
  );

endmodule

`default_nettype wire

[test/tb_grid_cell_growth_update_unit.sv]
// Self-checking testbench for the grid cell growth update unit against a cell-grid mirror.
module tb_grid_cell_growth_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gcgu_pkg::*;

  // Geometry of the instance under test (defaults of the top level).
  localparam int CELL_COLS = 8;
  localparam int CELL_ROWS = 8;
  localparam int NODE_ROWS = 7;

  // This pause covers a detection that yields no cell at all and is still
  // being worked on inside the block.
  localparam int SETTLE_CYCLES = 30;
  // Roughly 1600 detections, plus the clearing pass and phase pauses, taken
  // several times over.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SHOWN_ERRORS  = 10;

  localparam logic [15:0] Q88_ONE = 16'h0100;

  // One detection as it crosses the input channel.
  typedef struct packed {
    logic [3:0]  nx;
    logic [3:0]  ny;
    face_t       face;
    logic [15:0] cw;
    logic [15:0] bw;
    logic [15:0] rw;
  } det_t;

  // One updated cell as it crosses the result channel.
  typedef struct packed {
    logic [2:0]  col;
    logic [2:0]  row;
    logic [31:0] value;
    logic        clamped;
    logic        last;
  } cell_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // Source side of the detection channel, driven on the falling edge.
  logic        src_valid = 1'b0;
  det_t        src_det = '0;
  // Sink side of the result channel.
  logic        sink_ready = 1'b0;

  // Set while idling is switched off on both sides.
  bit          calm = 1'b0;

  det_t        det_q[$];        // detections not yet handed to the driver
  int          dets_waiting = 0; // queued but not yet transferred
  bit          in_took = 1'b0;  // a detection was transferred at the last rising edge

  // Mirror of the block: the cell grid, the ceiling and the cells still owed.
  logic [31:0] grid_mirror [CELL_COLS*CELL_ROWS];
  logic [31:0] max_mirror;
  cell_res_t   due_cells[$];

  int          mismatches = 0;
  int          cycle_count = 0;

  gcgu_in_if  det_ch ();
  gcgu_out_if cell_ch ();

  assign det_ch.valid         = src_valid;
  assign det_ch.node_x        = src_det.nx;
  assign det_ch.node_y        = src_det.ny;
  assign det_ch.facing        = src_det.face;
  assign det_ch.common_weight = src_det.cw;
  assign det_ch.base_weight   = src_det.bw;
  assign det_ch.road_weight   = src_det.rw;
  assign cell_ch.ready        = sink_ready;

  grid_cell_growth_update_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (det_ch),
    .out_ch    (cell_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the cells one detection updates and the values they take,
  // updates the mirror grid and queues the expected results in order.
  task automatic apply_detection(input det_t d);
    int          cx, cy, idx, last_k;
    int          cc [2];
    int          rr [2];
    bit          on_grid [2];
    logic [47:0] wprod;
    logic [39:0] factor;
    logic [71:0] grown;
    logic [55:0] scaled;
    cell_res_t   res;
    cx = $signed(d.nx) + 1;
    // Y runs the other way on the grid
    cy = NODE_ROWS - ($signed(d.ny) + 1) - 1;
    case (d.face)
      FACE_0: begin
        cc[0] = cx;     rr[0] = cy - 1;
        cc[1] = cx - 1; rr[1] = cy - 1;
      end
      FACE_90: begin
        cc[0] = cx;     rr[0] = cy;
        cc[1] = cx;     rr[1] = cy - 1;
      end
      FACE_180: begin
        cc[0] = cx;     rr[0] = cy;
        cc[1] = cx - 1; rr[1] = cy;
      end
      default: begin
        cc[0] = cx - 1; rr[0] = cy;
        cc[1] = cx - 1; rr[1] = cy - 1;
      end
    endcase
    last_k = -1;
    for (int k = 0; k < 2; k++) begin
      on_grid[k] = cc[k] >= 0 && cc[k] < CELL_COLS &&
                   rr[k] >= 0 && rr[k] < CELL_ROWS;
      if (on_grid[k]) last_k = k;
    end
    // Q8.8 cubed is Q24.24; dropping 8 bits leaves a Q24.16 factor
    wprod  = d.cw * d.bw * d.rw;
    factor = wprod[47:8];
    for (int k = 0; k < 2; k++) begin
      if (on_grid[k]) begin
        idx    = rr[k] * CELL_COLS + cc[k];
        grown  = grid_mirror[idx] * factor;
        scaled = grown[71:16];
        res.col  = 3'(cc[k]);
        res.row  = 3'(rr[k]);
        res.last = (k == last_k);
        if (scaled > {24'd0, max_mirror}) begin
          res.value   = max_mirror;
          res.clamped = 1'b1;
        end else begin
          res.value   = scaled[31:0];
          res.clamped = 1'b0;
        end
        grid_mirror[idx] = res.value;
        due_cells.push_back(res);
      end
    end
  endtask

  task automatic flag_mismatch(input string why, input cell_res_t want, input cell_res_t got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS)
      $display({"%0t mismatch (%s): exp col=%0d row=%0d val=%h clamp=%b last=%b,",
                " got col=%0d row=%0d val=%h clamp=%b last=%b"},
               $realtime, why, want.col, want.row, want.value, want.clamped, want.last,
               got.col, got.row, got.value, got.clamped, got.last);
  endtask

  // Rising edge: every transfer on either channel and every register write
  // is seen here, so the mirror moves in step with the block.
  always @(posedge clk) begin
    cell_res_t got, want;
    in_took <= det_ch.valid && det_ch.ready;
    if (!rst_n) begin
      for (int i = 0; i < CELL_COLS*CELL_ROWS; i++) grid_mirror[i] = CELL_ONE;
      max_mirror = CELL_MAX_RST;
      due_cells.delete();
    end else begin
      if (cfg_we) max_mirror = cfg_wdata;
      // Results first: a cell transferred now cannot stem from a detection
      // transferred at this same edge.
      if (cell_ch.valid && cell_ch.ready) begin
        got = {cell_ch.cell_col, cell_ch.cell_row, cell_ch.cell_value,
               cell_ch.was_clamped, cell_ch.last_of_run};
        if (due_cells.size() == 0) begin
          flag_mismatch("no result due", '0, got);
        end else begin
          want = due_cells.pop_front();
          if (got.col !== want.col || got.row !== want.row || got.value !== want.value ||
              got.clamped !== want.clamped || got.last !== want.last)
            flag_mismatch("field differs", want, got);
        end
      end
      if (det_ch.valid && det_ch.ready) begin
        apply_detection(src_det);
        dets_waiting--;
      end
    end
  end

  // Detection source: holds an item until it is transferred, then either
  // takes the next one or, at random, idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else if (!src_valid || in_took) begin
      if (det_q.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
        src_det   <= det_q.pop_front();
        src_valid <= 1'b1;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Result sink: stalls at random about 7 times in a hundred unless calm.
  always @(negedge clk) begin
    sink_ready <= calm || $urandom_range(99) >= 7;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_det(input int nx, input int ny, input face_t f,
                           input logic [15:0] cw, input logic [15:0] bw,
                           input logic [15:0] rw);
    det_t d;
    d.nx   = 4'(nx);
    d.ny   = 4'(ny);
    d.face = f;
    d.cw   = cw;
    d.bw   = bw;
    d.rw   = rw;
    dets_waiting++;
    det_q.push_back(d);
  endtask

  // Mostly near 1.0 so the grid wanders rather than pinning at the ceiling.
  function automatic logic [15:0] pick_weight();
    int sel = $urandom_range(9);
    if (sel < 6) return 16'($urandom_range(16'h0140, 16'h00C0));
    if (sel < 8) return 16'($urandom_range(16'h0400));
    return 16'($urandom());
  endfunction

  // Waits until every detection is transferred and every cell is back, then
  // lets a detection without results run out inside the block.
  task automatic wait_quiet();
    while (dets_waiting != 0 || due_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_ceiling(input logic [31:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [31:0] ceilings [6];
    int          phase_len [6];
    int          px, py;
    ceilings  = '{32'hFFFF_FFFF, $urandom(), 32'h0000_4000, $urandom(),
                  CELL_MAX_RST, 32'h0000_0000};
    phase_len = '{300, 300, 300, 300, 330, 30};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, ceiling at its reset value of 10.0. The block clears
    // its grid first; the source simply waits for ready.
    // 1.0 * 10.0 lands exactly on the ceiling: not clamped
    queue_det(0, 0, FACE_0, 16'h0A00, Q88_ONE, Q88_ONE);
    // same two cells doubled: over the ceiling, clamped
    queue_det(0, 0, FACE_0, 16'h0200, Q88_ONE, Q88_ONE);
    // both candidates off the grid: no result at all
    queue_det(7, 7, FACE_180, 16'h0300, Q88_ONE, Q88_ONE);
    // lowest stated position: one candidate off the left edge
    queue_det(-1, -1, FACE_0, 16'h0180, Q88_ONE, Q88_ONE);
    // most negative encodable position, far off the grid
    queue_det(-8, -8, FACE_90, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_det(7, 0, FACE_270, 16'h0080, 16'h0300, Q88_ONE);
    // right-hand candidate beyond the last column, second one kept
    queue_det(7, 3, FACE_180, 16'h0120, 16'h00E0, Q88_ONE);
    // first candidate on row 0, second above the grid
    queue_det(3, 5, FACE_90, 16'h0110, Q88_ONE, 16'h00F0);
    queue_det(2, 6, FACE_90, 16'h0200, Q88_ONE, Q88_ONE);
    // largest weights: huge factor, clamped
    queue_det(4, 2, FACE_0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_det(-1, 7, FACE_270, 16'h0200, Q88_ONE, Q88_ONE);
    queue_det(6, -1, FACE_180, 16'h0140, 16'h00C0, 16'h0155);
    // position past the stated range lands on the bottom row; zero weight
    queue_det(6, -2, FACE_180, 16'h0000, Q88_ONE, Q88_ONE);
    // factor truncates to zero
    queue_det(6, -2, FACE_180, 16'h0001, 16'h0001, 16'h0001);
    queue_det(-2, 3, FACE_0, 16'h0300, Q88_ONE, Q88_ONE);
    queue_det(2, 1, FACE_270, 16'h7FFF, 16'h8000, 16'h0001);
    queue_det(5, 4, FACE_90, Q88_ONE, Q88_ONE, 16'h00FF);
    queue_det(1, 2, FACE_270, 16'h5555, 16'hAAAA, 16'h0002);

    // Random phases, one ceiling each. The source holds off at every phase
    // boundary until all owed cells are back. The first phase runs with no
    // idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      write_ceiling(ceilings[ph]);
      calm = (ph == 0);
      for (int k = 0; k < phase_len[ph]; k++) begin
        // mostly stated positions; the rest anywhere in the 4-bit range
        if ($urandom_range(99) < 85) begin
          px = $urandom_range(8) - 1;
          py = $urandom_range(8) - 1;
        end else begin
          px = $urandom_range(15);
          py = $urandom_range(15);
        end
        queue_det(px, py, face_t'($urandom_range(3)), pick_weight(), pick_weight(),
                  pick_weight());
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
